[design/gpg_pkg.sv]
// shared constants, types and helper functions of the gradient pixel generator
package gpg_pkg;

	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 24;
	localparam int LEN_W      = 12;
	localparam int PCT_W      = 7;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUO_W      = 8;
	localparam int NUM_W      = LEN_W + CHAN_W;
	localparam int PROD_W     = 2 * CHAN_W;
	localparam int RGB_N      = 3;
	localparam int LANES      = RGB_N + 1;
	localparam int LANE_FADE  = RGB_N;

	localparam logic [CHAN_W-1:0] ALPHA_MAX = 8'hFF;

	// x / 255 for 16-bit x as a multiply by 2^23 / 255, rounded up
	localparam int DIV255_MUL   = 32897;
	localparam int DIV255_MUL_W = 17;
	localparam int DIV255_SHIFT = 23;

	// y / 100 for y below 2^15 as a multiply by 2^19 / 100, rounded up
	localparam int PCT_MUL      = 5243;
	localparam int PCT_PROD_W   = PCT_W + CHAN_W;
	localparam int PCT_MUL_W    = PCT_PROD_W + 14;
	localparam int PCT_SHIFT    = 19;
	localparam int PCT_QUO_W    = PCT_MUL_W - PCT_SHIFT;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_FIRST   = 3'd0,
		REG_COLOR_SECOND  = 3'd1,
		REG_SPAN_LENGTH   = 3'd2,
		REG_ALPHA_PERCENT = 3'd3,
		REG_FILL_MODE     = 3'd4,
		REG_RAMP_FORWARD  = 3'd5,
		REG_AXIS_VERTICAL = 3'd6
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_FLAT  = 2'd0,
		MODE_BLEND = 2'd1,
		MODE_FADE  = 2'd2
	} fill_mode_t;

	typedef logic [CHAN_W-1:0] chan_t;

	// one word of the divider pipeline: red, green, blue and fade lanes
	typedef struct packed {
		logic [LANES-1:0][NUM_W-1:0] rem;
		logic [LANES-1:0][QUO_W-1:0] quo;
		logic                        clamped;
	} div_word_t;

	function automatic chan_t color_chan(logic [COLOR_W-1:0] color, int unsigned k);
		return color[k*CHAN_W +: CHAN_W];
	endfunction

	// floor(percent * 255 / 100), saturated
	function automatic chan_t flat_alpha(logic [PCT_W-1:0] pct);
		logic [PCT_PROD_W-1:0] v;
		logic [PCT_MUL_W-1:0]  m;
		logic [PCT_QUO_W-1:0]  q;
		v = {pct, CHAN_W'(0)} - PCT_PROD_W'(pct);
		m = PCT_MUL_W'(v) * PCT_MUL_W'(PCT_MUL);
		q = m[PCT_SHIFT +: PCT_QUO_W];
		return (q > PCT_QUO_W'(ALPHA_MAX)) ? ALPHA_MAX : q[CHAN_W-1:0];
	endfunction

	function automatic chan_t div255(logic [PROD_W-1:0] x);
		logic [PROD_W+DIV255_MUL_W-1:0] m;
		m = (PROD_W+DIV255_MUL_W)'(x) * (PROD_W+DIV255_MUL_W)'(DIV255_MUL);
		return m[DIV255_SHIFT +: CHAN_W];
	endfunction

endpackage

[design/gpg_ifs.sv]
// handshake channels of the gradient pixel generator: coordinates, pixels, configuration
interface gpg_coord_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;

	modport source (output valid, pos_x, pos_y, input ready);
	modport sink (input valid, pos_x, pos_y, output ready);
endinterface

interface gpg_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [gpg_pkg::CHAN_W-1:0] out_alpha;
	logic [gpg_pkg::CHAN_W-1:0] out_red;
	logic [gpg_pkg::CHAN_W-1:0] out_green;
	logic [gpg_pkg::CHAN_W-1:0] out_blue;
	logic                       pos_clamped;

	modport source (output valid, out_alpha, out_red, out_green, out_blue, pos_clamped,
		input ready);
	modport sink (input valid, out_alpha, out_red, out_green, out_blue, pos_clamped,
		output ready);
endinterface

interface gpg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gpg_pkg::CFG_IDX_W-1:0]  index;
	logic [gpg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/gpg_div_stage.sv]
// one restoring-division step for all lanes: one quotient bit per stage, with its own handshake
module gpg_div_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        feed_valid,
	output logic                        feed_ready,
	input  gpg_pkg::div_word_t          feed_word,
	input  logic [gpg_pkg::NUM_W-1:0]   divisor,
	output logic                        drain_valid,
	input  logic                        drain_ready,
	output gpg_pkg::div_word_t          drain_word
);

	logic               valid_q;
	gpg_pkg::div_word_t word_q;
	gpg_pkg::div_word_t word_d;

	always_comb begin
		word_d.clamped = feed_word.clamped;
		for (int l = 0; l < gpg_pkg::LANES; l++) begin
			if (feed_word.rem[l] >= divisor) begin
				word_d.rem[l] = feed_word.rem[l] - divisor;
				word_d.quo[l] = {feed_word.quo[l][gpg_pkg::QUO_W-2:0], 1'b1};
			end else begin
				word_d.rem[l] = feed_word.rem[l];
				word_d.quo[l] = {feed_word.quo[l][gpg_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign feed_ready  = !valid_q || drain_ready;
	assign drain_valid = valid_q;
	assign drain_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (feed_ready) begin
			valid_q <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed_ready && feed_valid) begin
			word_q <= word_d;
		end
	end

endmodule

[design/gradient_pixel_generator.sv]
// Linear colour gradient with premultiplied alpha. One pixel coordinate in, one ARGB pixel
// out, one pixel per clock sustained while the pixel sink is ready. Three stages pick and
// clamp the position and build the blend and fade numerators, eight stages divide by the span
// length one quotient bit each, and two stages premultiply by alpha and divide by 255.
// Every stage has its own valid bit and stalls only when the stage after it is full.
// Configuration words are taken in any cycle and must be written only while the pipeline
// is empty; the flat-mode alpha is a register fed from the percent register.
module gradient_pixel_generator #(
	parameter int COORD_BITS = 12
) (
	input logic        clk,
	input logic        arst_n,
	gpg_cfg_if.sink    cfg,
	gpg_coord_if.sink  coord,
	gpg_pixel_if.source pixel
);

	localparam int CHAN_W  = gpg_pkg::CHAN_W;
	localparam int LEN_W   = gpg_pkg::LEN_W;
	localparam int NUM_W   = gpg_pkg::NUM_W;
	localparam int QUO_W   = gpg_pkg::QUO_W;
	localparam int PROD_W  = gpg_pkg::PROD_W;
	localparam int RGB_N   = gpg_pkg::RGB_N;
	localparam int CMP_W   = (COORD_BITS > LEN_W) ? COORD_BITS : LEN_W;

	// configuration registers
	logic [gpg_pkg::COLOR_W-1:0] color_first_q;
	logic [gpg_pkg::COLOR_W-1:0] color_second_q;
	logic [LEN_W-1:0]            span_length_q;
	logic [gpg_pkg::PCT_W-1:0]   alpha_percent_q;
	logic [gpg_pkg::MODE_W-1:0]  fill_mode_q;
	logic                        ramp_forward_q;
	logic                        axis_vertical_q;
	logic [CHAN_W-1:0]           flat_alpha_q;
	logic [LEN_W-1:0]            span_len;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_first_q   <= '0;
			color_second_q  <= '0;
			span_length_q   <= LEN_W'(1);
			alpha_percent_q <= gpg_pkg::PCT_W'(100);
			fill_mode_q     <= gpg_pkg::MODE_FLAT;
			ramp_forward_q  <= 1'b0;
			axis_vertical_q <= 1'b0;
			flat_alpha_q    <= gpg_pkg::ALPHA_MAX;
		end else begin
			flat_alpha_q <= gpg_pkg::flat_alpha(alpha_percent_q);
			if (cfg.valid && cfg.ready) begin
				case (gpg_pkg::cfg_reg_t'(cfg.index))
					gpg_pkg::REG_COLOR_FIRST: begin
						color_first_q <= cfg.data[gpg_pkg::COLOR_W-1:0];
					end
					gpg_pkg::REG_COLOR_SECOND: begin
						color_second_q <= cfg.data[gpg_pkg::COLOR_W-1:0];
					end
					gpg_pkg::REG_SPAN_LENGTH: begin
						span_length_q <= cfg.data[LEN_W-1:0];
					end
					gpg_pkg::REG_ALPHA_PERCENT: begin
						alpha_percent_q <= cfg.data[gpg_pkg::PCT_W-1:0];
					end
					gpg_pkg::REG_FILL_MODE: begin
						fill_mode_q <= cfg.data[gpg_pkg::MODE_W-1:0];
					end
					gpg_pkg::REG_RAMP_FORWARD: begin
						ramp_forward_q <= cfg.data[0];
					end
					gpg_pkg::REG_AXIS_VERTICAL: begin
						axis_vertical_q <= cfg.data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// a zero span acts as one
	assign span_len = (span_length_q == '0) ? LEN_W'(1) : span_length_q;

	// stage load enables, back to front
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [QUO_W:0] div_valid;
	logic [QUO_W:0] div_ready;
	gpg_pkg::div_word_t div_word [QUO_W+1];
	logic [QUO_W-1:0][NUM_W-1:0] div_den;

	assign adv_s5 = !v_s5 || pixel.ready;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || div_ready[0];
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign coord.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= coord.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= div_valid[QUO_W];
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: pick the axis, clamp to the span, form the blend weights
	logic [COORD_BITS-1:0] p_raw;
	logic [CMP_W-1:0]      p_wide;
	logic                  clamp;
	logic [LEN_W-1:0]      p_clip;
	logic [LEN_W-1:0]      w1, w2;
	logic [LEN_W-1:0]      p_s1, w1_s1, w2_s1;
	logic                  clamp_s1;

	always_comb begin
		p_raw  = axis_vertical_q ? coord.pos_y : coord.pos_x;
		p_wide = CMP_W'(p_raw);
		clamp  = p_wide > CMP_W'(span_len);
		p_clip = clamp ? span_len : p_wide[LEN_W-1:0];
		w2     = ramp_forward_q ? p_clip : span_len - p_clip;
		w1     = span_len - w2;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && coord.valid) begin
			p_s1     <= p_clip;
			w1_s1    <= w1;
			w2_s1    <= w2;
			clamp_s1 <= clamp;
		end
	end

	// stage 2: weighted colour terms and the fade numerator p * 255
	logic [RGB_N-1:0][NUM_W-1:0] prod_a_s2, prod_b_s2;
	logic [NUM_W-1:0]            fade_s2;
	logic                        clamp_s2;

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			for (int l = 0; l < RGB_N; l++) begin
				prod_a_s2[l] <= NUM_W'(gpg_pkg::color_chan(color_first_q, l)) * NUM_W'(w1_s1);
				prod_b_s2[l] <= NUM_W'(gpg_pkg::color_chan(color_second_q, l)) * NUM_W'(w2_s1);
			end
			fade_s2  <= {p_s1, CHAN_W'(0)} - NUM_W'(p_s1);
			clamp_s2 <= clamp_s1;
		end
	end

	// stage 3: blend numerators, fade numerator passed on
	logic [gpg_pkg::LANES-1:0][NUM_W-1:0] num_s3;
	logic                                 clamp_s3;

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			for (int l = 0; l < RGB_N; l++) begin
				num_s3[l] <= prod_a_s2[l] + prod_b_s2[l];
			end
			num_s3[gpg_pkg::LANE_FADE] <= fade_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// division by the span length, most significant quotient bit first
	assign div_valid[0]        = v_s3;
	assign div_word[0].rem     = num_s3;
	assign div_word[0].quo     = '0;
	assign div_word[0].clamped = clamp_s3;
	assign div_ready[QUO_W]    = adv_s4;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int SH = QUO_W - 1 - k;
		assign div_den[k] = NUM_W'(span_len) << SH;

		gpg_div_stage u_stage (
			.clk         (clk),
			.arst_n      (arst_n),
			.feed_valid  (div_valid[k]),
			.feed_ready  (div_ready[k]),
			.feed_word   (div_word[k]),
			.divisor     (div_den[k]),
			.drain_valid (div_valid[k+1]),
			.drain_ready (div_ready[k+1]),
			.drain_word  (div_word[k+1])
		);
	end

	// stage 4: pick alpha and colour per mode, multiply by alpha
	logic [CHAN_W-1:0]            alpha;
	logic [CHAN_W-1:0]            fade_q;
	logic [RGB_N-1:0][CHAN_W-1:0] rgb;
	logic [CHAN_W-1:0]            alpha_s4;
	logic [RGB_N-1:0][PROD_W-1:0] prod_s4;
	logic                         clamp_s4;

	always_comb begin
		fade_q = div_word[QUO_W].quo[gpg_pkg::LANE_FADE];
		for (int l = 0; l < RGB_N; l++) begin
			rgb[l] = gpg_pkg::color_chan(color_first_q, l);
		end
		case (gpg_pkg::fill_mode_t'(fill_mode_q))
			gpg_pkg::MODE_BLEND: begin
				alpha = gpg_pkg::ALPHA_MAX;
				for (int l = 0; l < RGB_N; l++) begin
					rgb[l] = div_word[QUO_W].quo[l];
				end
			end
			gpg_pkg::MODE_FADE: begin
				alpha = ramp_forward_q ? gpg_pkg::ALPHA_MAX - fade_q : fade_q;
			end
			default: begin
				alpha = flat_alpha_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && div_valid[QUO_W]) begin
			alpha_s4 <= alpha;
			for (int l = 0; l < RGB_N; l++) begin
				prod_s4[l] <= PROD_W'(rgb[l]) * PROD_W'(alpha);
			end
			clamp_s4 <= div_word[QUO_W].clamped;
		end
	end

	// stage 5: divide by 255, output word
	logic [CHAN_W-1:0]            alpha_s5;
	logic [RGB_N-1:0][CHAN_W-1:0] chan_s5;
	logic                         clamp_s5;

	always_ff @(posedge clk) begin
		if (adv_s5 && v_s4) begin
			alpha_s5 <= alpha_s4;
			for (int l = 0; l < RGB_N; l++) begin
				chan_s5[l] <= gpg_pkg::div255(prod_s4[l]);
			end
			clamp_s5 <= clamp_s4;
		end
	end

	assign pixel.valid       = v_s5;
	assign pixel.out_alpha   = alpha_s5;
	assign pixel.out_red     = chan_s5[0];
	assign pixel.out_green   = chan_s5[1];
	assign pixel.out_blue    = chan_s5[2];
	assign pixel.pos_clamped = clamp_s5;

endmodule

[tb/sv/tb_gradient_pixel_generator.sv]
// testbench of the gradient pixel generator: directed table, random phases, pixel scoreboard
`timescale 1ns / 1ps

module tb_gradient_pixel_generator;

	localparam int COORD_BITS      = 12;
	localparam int RESET_CYCLES    = 12;
	localparam int DRAIN_PAD       = 16;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int MAX_REPORTS     = 10;

	localparam int CHAN_W     = gpg_pkg::CHAN_W;
	localparam int COLOR_W    = gpg_pkg::COLOR_W;
	localparam int LEN_W      = gpg_pkg::LEN_W;
	localparam int PCT_W      = gpg_pkg::PCT_W;
	localparam int MODE_W     = gpg_pkg::MODE_W;
	localparam int CFG_IDX_W  = gpg_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gpg_pkg::CFG_DATA_W;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [COLOR_W-1:0] first;
		logic [COLOR_W-1:0] second;
		logic [LEN_W-1:0]   span;
		logic [PCT_W-1:0]   pct;
		logic [MODE_W-1:0]  mode;
		logic               fwd;
		logic               axis;
	} grad_cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              clamped;
	} pixel_t;

	typedef struct {
		grad_cfg_t             cfg;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		bit                    typed;
		pixel_t                want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	gpg_cfg_if                           cfg_ch();
	gpg_coord_if #(.COORD_BITS(COORD_BITS)) coord_ch();
	gpg_pixel_if                         pix_ch();

	gradient_pixel_generator #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.coord  (coord_ch),
		.pixel  (pix_ch)
	);

	grad_cfg_t grad_regs;
	pixel_t    pending_pixels[$];
	dir_row_t  dir_rows[$];
	int        mismatches;
	int        idle_cycles;
	bit        burst;
	bit        hold_req;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic grad_cfg_t mk_cfg(logic [COLOR_W-1:0] first,
		logic [COLOR_W-1:0] second, logic [LEN_W-1:0] span, logic [PCT_W-1:0] pct,
		logic [MODE_W-1:0] mode, logic fwd, logic axis);
		grad_cfg_t c;
		c.first  = first;
		c.second = second;
		c.span   = span;
		c.pct    = pct;
		c.mode   = mode;
		c.fwd    = fwd;
		c.axis   = axis;
		return c;
	endfunction

	function automatic pixel_t mk_pix(logic [7:0] a, logic [7:0] r, logic [7:0] g,
		logic [7:0] b, logic c);
		pixel_t p;
		p.alpha   = a;
		p.red     = r;
		p.green   = g;
		p.blue    = b;
		p.clamped = c;
		return p;
	endfunction

	function automatic int unsigned eff_span();
		return (grad_regs.span == 0) ? 1 : 32'(grad_regs.span);
	endfunction

	function automatic pixel_t predict_pixel(logic [COORD_BITS-1:0] x,
		logic [COORD_BITS-1:0] y);
		int unsigned len, p, w1, w2, f, alpha;
		int unsigned ca[3];
		int unsigned cb[3];
		int unsigned ch[3];
		pixel_t r;
		len = eff_span();
		p = grad_regs.axis ? 32'(y) : 32'(x);
		r.clamped = 1'b0;
		if (p > len) begin
			p = len;
			r.clamped = 1'b1;
		end
		for (int k = 0; k < 3; k++) begin
			ca[k] = 32'(grad_regs.first[8*k +: 8]);
			cb[k] = 32'(grad_regs.second[8*k +: 8]);
			ch[k] = ca[k];
		end
		case (grad_regs.mode)
			gpg_pkg::MODE_BLEND: begin
				w2 = grad_regs.fwd ? p : len - p;
				w1 = len - w2;
				for (int k = 0; k < 3; k++)
					ch[k] = (ca[k] * w1 + cb[k] * w2) / len;
				alpha = 255;
			end
			gpg_pkg::MODE_FADE: begin
				f = (p * 255) / len;
				alpha = grad_regs.fwd ? 255 - f : f;
			end
			default: begin
				alpha = (32'(grad_regs.pct) * 255) / 100;
				if (alpha > 255)
					alpha = 255;
			end
		endcase
		r.alpha = alpha[7:0];
		r.red   = 8'((ch[0] * alpha) / 255);
		r.green = 8'((ch[1] * alpha) / 255);
		r.blue  = 8'((ch[2] * alpha) / 255);
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	function automatic grad_cfg_t rand_cfg();
		grad_cfg_t c;
		c.first  = pick_color();
		c.second = pick_color();
		case ($urandom_range(0, 7))
			0: c.span = 0;
			1: c.span = 1;
			2: c.span = 4095;
			3, 4: c.span = LEN_W'($urandom_range(2, 64));
			default: c.span = LEN_W'($urandom_range(1, 4095));
		endcase
		if ($urandom_range(0, 3) == 0)
			c.pct = PCT_W'($urandom_range(101, 127));
		else
			c.pct = PCT_W'($urandom_range(0, 100));
		c.mode = MODE_W'($urandom_range(0, 6) / 2);
		c.fwd  = 1'($urandom_range(0, 1));
		c.axis = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// mostly inside the span, some just around its end, some anywhere
	function automatic logic [COORD_BITS-1:0] pick_pos(int unsigned len);
		case ($urandom_range(0, 5))
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'(len + $urandom_range(0, 2) - 1);
			default: return COORD_BITS'($urandom_range(0, len));
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			gpg_pkg::REG_COLOR_FIRST:   grad_regs.first  = value[COLOR_W-1:0];
			gpg_pkg::REG_COLOR_SECOND:  grad_regs.second = value[COLOR_W-1:0];
			gpg_pkg::REG_SPAN_LENGTH:   grad_regs.span   = value[LEN_W-1:0];
			gpg_pkg::REG_ALPHA_PERCENT: grad_regs.pct    = value[PCT_W-1:0];
			gpg_pkg::REG_FILL_MODE:     grad_regs.mode   = value[MODE_W-1:0];
			gpg_pkg::REG_RAMP_FORWARD:  grad_regs.fwd    = value[0];
			gpg_pkg::REG_AXIS_VERTICAL: grad_regs.axis   = value[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		@(negedge clk);
		coord_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic apply_cfg(grad_cfg_t c);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		wait_drained();
		// upper data bits beyond each field carry junk
		write_reg(gpg_pkg::REG_COLOR_FIRST, c.first);
		write_reg(gpg_pkg::REG_COLOR_SECOND, c.second);
		write_reg(gpg_pkg::REG_SPAN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], c.span});
		write_reg(gpg_pkg::REG_ALPHA_PERCENT, {junk[CFG_DATA_W-1:PCT_W], c.pct});
		write_reg(gpg_pkg::REG_FILL_MODE, {junk[CFG_DATA_W-1:MODE_W], c.mode});
		write_reg(gpg_pkg::REG_RAMP_FORWARD, {junk[CFG_DATA_W-1:1], c.fwd});
		write_reg(gpg_pkg::REG_AXIS_VERTICAL, {junk[CFG_DATA_W-1:1], c.axis});
		write_reg(REG_UNUSED, junk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_coord(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, bit typed,
		pixel_t want);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			coord_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		coord_ch.valid <= 1'b1;
		coord_ch.pos_x <= x;
		coord_ch.pos_y <= y;
		@(posedge clk);
		while (!coord_ch.ready)
			@(posedge clk);
		pending_pixels.push_back(typed ? want : predict_pixel(x, y));
	endtask

	task automatic add_row(grad_cfg_t c, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
		bit typed, pixel_t want);
		dir_row_t r;
		r.cfg   = c;
		r.x     = x;
		r.y     = y;
		r.typed = typed;
		r.want  = want;
		dir_rows.push_back(r);
	endtask

	task automatic build_rows();
		grad_cfg_t c;
		pixel_t    nul;
		nul = '0;
		// reset state: flat, opaque, black, span of one
		c = mk_cfg(0, 0, 1, 100, gpg_pkg::MODE_FLAT, 0, 0);
		add_row(c, 0, 0, 1, mk_pix(8'hFF, 0, 0, 0, 0));
		add_row(c, 1, 5, 1, mk_pix(8'hFF, 0, 0, 0, 0));
		add_row(c, 4095, 4095, 1, mk_pix(8'hFF, 0, 0, 0, 1));
		c = mk_cfg(24'hFFFFFF, 0, 4095, 100, gpg_pkg::MODE_FLAT, 0, 0);
		add_row(c, 4095, 0, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		add_row(c, 0, 4095, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		c = mk_cfg(24'hFFFFFF, 0, 4095, 0, gpg_pkg::MODE_FLAT, 0, 0);
		add_row(c, 123, 0, 1, mk_pix(0, 0, 0, 0, 0));
		// percent above hundred saturates
		c = mk_cfg(24'hFFFFFF, 0, 4095, 127, gpg_pkg::MODE_FLAT, 0, 0);
		add_row(c, 7, 9, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		c = mk_cfg(24'h123456, 24'h654321, 4095, 50, gpg_pkg::MODE_FLAT, 0, 0);
		add_row(c, 77, 3, 0, nul);
		// blend, red first and blue second
		c = mk_cfg(24'h0000FF, 24'hFF0000, 100, 100, gpg_pkg::MODE_BLEND, 0, 0);
		add_row(c, 0, 0, 1, mk_pix(8'hFF, 0, 0, 8'hFF, 0));
		add_row(c, 50, 0, 0, nul);
		add_row(c, 100, 0, 1, mk_pix(8'hFF, 8'hFF, 0, 0, 0));
		add_row(c, 300, 0, 1, mk_pix(8'hFF, 8'hFF, 0, 0, 1));
		c = mk_cfg(24'h0000FF, 24'hFF0000, 100, 100, gpg_pkg::MODE_BLEND, 1, 1);
		add_row(c, 4095, 0, 1, mk_pix(8'hFF, 8'hFF, 0, 0, 0));
		add_row(c, 0, 100, 1, mk_pix(8'hFF, 0, 0, 8'hFF, 0));
		add_row(c, 9, 37, 0, nul);
		c = mk_cfg(24'hFFFFFF, 0, 255, 100, gpg_pkg::MODE_FADE, 0, 0);
		add_row(c, 0, 0, 1, mk_pix(0, 0, 0, 0, 0));
		add_row(c, 128, 0, 0, nul);
		add_row(c, 255, 0, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		c = mk_cfg(24'hFFFFFF, 0, 255, 100, gpg_pkg::MODE_FADE, 1, 0);
		add_row(c, 0, 0, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		add_row(c, 4095, 0, 1, mk_pix(0, 0, 0, 0, 1));
		// zero span acts as a span of one
		c = mk_cfg(24'hFFFFFF, 0, 0, 100, gpg_pkg::MODE_FADE, 0, 0);
		add_row(c, 0, 0, 1, mk_pix(0, 0, 0, 0, 0));
		add_row(c, 1, 0, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		add_row(c, 2, 0, 1, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1));
		// unused mode behaves as flat, clamp still flagged
		c = mk_cfg(24'h808080, 24'hFFFFFF, 10, 60, MODE_UNUSED, 1, 0);
		add_row(c, 5, 0, 0, nul);
		add_row(c, 4095, 0, 0, nul);
	endtask

	// pixel receiver: random stall per word outside bursts, plus one long hold-off on request
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		pix_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 8);
			if (hold_req && !held) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				@(negedge clk);
				pix_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			pix_ch.ready <= 1'b1;
			@(posedge clk);
			while (!pix_ch.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : pixel_check
		pixel_t want;
		pixel_t got;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			got = mk_pix(pix_ch.out_alpha, pix_ch.out_red, pix_ch.out_green, pix_ch.out_blue,
				pix_ch.pos_clamped);
			if (pending_pixels.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected pixel a=%h r=%h g=%h b=%h c=%b",
						got.alpha, got.red, got.green, got.blue, got.clamped);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (got.alpha != want.alpha || got.red != want.red ||
					got.green != want.green || got.blue != want.blue ||
					got.clamped != want.clamped) begin
					if (mismatches < MAX_REPORTS)
						$display("pixel mismatch: want %h %h %h %h %b, got %h %h %h %h %b",
							want.alpha, want.red, want.green, want.blue, want.clamped,
							got.alpha, got.red, got.green, got.blue, got.clamped);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (coord_ch.valid && coord_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("gradient_pixel_generator verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		grad_cfg_t             c;
		int unsigned           len;
		logic [COORD_BITS-1:0] pos;
		logic [COORD_BITS-1:0] other;
		arst_n         = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		coord_ch.valid = 1'b0;
		coord_ch.pos_x = '0;
		coord_ch.pos_y = '0;
		burst          = 1'b0;
		hold_req       = 1'b0;
		grad_regs      = mk_cfg(0, 0, 1, 100, gpg_pkg::MODE_FLAT, 0, 0);
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_rows();
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg != grad_regs)
				apply_cfg(dir_rows[i].cfg);
			send_coord(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: c = mk_cfg('1, '1, 4095, 127, MODE_UNUSED, 1, 1);
				1: c = mk_cfg(0, 0, 0, 0, gpg_pkg::MODE_FLAT, 0, 0);
				default: c = rand_cfg();
			endcase
			apply_cfg(c);
			burst = (ph % 4 == 2);
			if (ph == 3)
				hold_req = 1'b1;
			len = eff_span();
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// sender pause until the pipeline has emptied
				if (ph == 6 && i == ITEMS_PER_PHASE / 2)
					wait_drained();
				pos   = pick_pos(len);
				other = COORD_BITS'($urandom);
				if (grad_regs.axis)
					send_coord(other, pos, 1'b0, '0);
				else
					send_coord(pos, other, 1'b0, '0);
			end
		end

		wait_drained();
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("gradient_pixel_generator verification clean");
		else
			$display("gradient_pixel_generator verification failed");
		$finish;
	end

endmodule
